/* rtl/core/smpq_pkg.sv */
// Package: item types, commands and defaults for the stable min priority queue.
`default_nettype none

package smpq_pkg;

  localparam int unsigned CapacityDef = 16;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic        [31:0] data_tag;
    logic signed [15:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] head_tag;
    logic signed [15:0] head_priority;
    logic               is_empty;
    logic        [4:0]  entry_count;
    logic               push_dropped;
  } out_item_t;

  // One stored slot
  typedef struct packed {
    logic        [31:0] tag;
    logic signed [15:0] pri;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/smpq_mem.sv */
// Slot memory: one write port, one read port with registered read data.
`default_nettype none

module smpq_mem #(
  parameter int unsigned CAPACITY = smpq_pkg::CapacityDef,
  localparam int unsigned IW = $clog2(CAPACITY)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IW-1:0]   waddr_i,
  input  wire smpq_pkg::entry_t wdata_i,
  input  wire logic [IW-1:0]   raddr_i,
  output smpq_pkg::entry_t     rdata_o
);

  smpq_pkg::entry_t mem_q [CAPACITY];
  smpq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/smpq_seq.sv */
// Sequencer: circular slot buffer, insertion walk with one shared priority compare.
`default_nettype none

module smpq_seq #(
  parameter int unsigned CAPACITY = smpq_pkg::CapacityDef,
  localparam int unsigned IW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire smpq_pkg::in_item_t in_item_i,
  output logic                    in_ready_o,
  output logic                    res_valid_o,
  output smpq_pkg::out_item_t     res_o,
  input  wire logic               res_ready_i,
  output logic                    mem_we_o,
  output logic [IW-1:0]           mem_waddr_o,
  output smpq_pkg::entry_t        mem_wdata_o,
  output logic [IW-1:0]           mem_raddr_o,
  input  wire smpq_pkg::entry_t   mem_rdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [IW:0]   CapW  = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CapC  = CW'(CAPACITY);
  localparam logic [IW-1:0] OneIx = IW'(1);
  localparam logic [IW-1:0] TwoIx = IW'(2);

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             drop_q, drop_d;
  smpq_pkg::entry_t new_q, new_d;

  logic [CW-1:0]    count_m1;
  logic [CW+4:0]    count_ext;
  logic             shift_up;

  // Logical position relative to head -> physical slot
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [IW-1:0] lg);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, lg};
    if (sum >= CapW) begin
      sum = sum - CapW;
    end
    return sum[IW-1:0];
  endfunction

  assign count_m1  = count_q - CW'(1);
  assign count_ext = {5'd0, count_q};
  // Stored entry strictly larger moves back; equal ones stay ahead
  assign shift_up  = ($signed(mem_rdata_i.pri) > $signed(new_q.pri));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    idx_d       = idx_q;
    drop_d      = drop_q;
    new_d       = new_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot_of(head_q, idx_q);
    mem_wdata_o = new_q;
    mem_raddr_o = head_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          drop_d    = 1'b0;
          new_d.tag = in_item_i.data_tag;
          new_d.pri = in_item_i.priority_req;
          if (in_item_i.cmd == smpq_pkg::CMD_PUSH) begin
            if (count_q >= CapC) begin
              drop_d  = 1'b1;
              state_d = S_FIN;
            end else begin
              count_d = count_q + CW'(1);
              idx_d   = count_q[IW-1:0];
              if (count_q == '0) begin
                state_d = S_INS;
              end else begin
                mem_raddr_o = slot_of(head_q, count_m1[IW-1:0]);
                state_d     = S_CMP;
              end
            end
          end else begin
            if (count_q != '0) begin
              count_d = count_m1;
              head_d  = slot_of(head_q, OneIx);
            end
            state_d = S_FIN;
          end
        end
      end
      S_CMP: begin
        mem_we_o = 1'b1;
        if (shift_up) begin
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_q - OneIx;
          if (idx_q == OneIx) begin
            state_d = S_INS;
          end else begin
            mem_raddr_o = slot_of(head_q, idx_q - TwoIx);
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_INS: begin
        mem_we_o = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.is_empty     = (count_q == '0);
    res_o.entry_count  = count_ext[4:0];
    res_o.push_dropped = drop_q;
    if (count_q == '0) begin
      res_o.head_tag      = '0;
      res_o.head_priority = '0;
    end else begin
      res_o.head_tag      = mem_rdata_i.tag;
      res_o.head_priority = mem_rdata_i.pri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      idx_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      idx_q   <= idx_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < CapW)
    else $error("head pointer out of range");

  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (idx_q != '0) && (count_q != '0))
    else $error("insertion walk at head position");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.cmd == smpq_pkg::CMD_POP && count_q != '0)
    |=> (count_q == $past(count_m1)))
    else $error("pop did not remove one item");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && drop_q) |-> (count_q == CapC))
    else $error("push dropped while not full");
`endif

endmodule

`default_nettype wire

/* rtl/core/stable_min_priority_queue.sv */
// Top level: stable min priority queue with registered result output.
`default_nettype none

// Bounded priority queue of (tag, priority) entries kept smallest first, first in
// first out among equal priorities. Entries live in a single-port-write,
// single-port-read slot memory used as a circular buffer, so a pop only moves
// the head pointer. A push walks from the tail toward the head one slot per
// cycle, comparing against the new priority and moving larger entries back.
// A pop or a dropped push goes straight to the finish and output states; a push
// first runs the insertion walk, whose length is set by the number of stored
// entries with a larger priority and by the memory's one read and one write port.
// in_ready_o is low while an item is at work. A result waits in the output
// register; the next item is accepted while it waits.
module stable_min_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::CapacityDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire smpq_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output smpq_pkg::out_item_t      out_item_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic                res_valid;
  logic                res_ready;
  smpq_pkg::out_item_t res;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [IW-1:0]       mem_raddr;
  smpq_pkg::entry_t    mem_wdata;
  smpq_pkg::entry_t    mem_rdata;

  logic                out_valid_q;
  smpq_pkg::out_item_t out_q;

  smpq_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (in_ready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  smpq_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
